// ===== rtl/core/byte_ring_fifo_with_stats_defines.svh =====
// Assertion macros for the byte ring FIFO block.
`ifndef BYTE_RING_FIFO_WITH_STATS_DEFINES_SVH
`define BYTE_RING_FIFO_WITH_STATS_DEFINES_SVH
`ifndef SYNTH
`define BRFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BRFS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BRFS_ASSERT(lbl, prop, msg)
`define BRFS_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/core/brfs_pkg.sv =====
// Shared types and constants of the byte ring FIFO block.
`default_nettype none
package brfs_pkg;
  localparam int SIZE_W   = 11;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;
  localparam int DATA_W   = 8;
  localparam int LEN_W    = 7;
  localparam int SEL_W    = 3;
  localparam int MOVED_W  = 11;
  localparam int LEVEL_W  = 11;
  localparam int SV_W     = 32;
  localparam int ACC_W    = 11;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 64;
  localparam int NUM_STATS = 5;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_OPEN  = 3'd2,
    OP_QUERY = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BLOCK = 2'd1;
  localparam logic [1:0] ST_AGAIN = 2'd2;

  localparam logic [SEL_W-1:0] STAT_WR    = 3'd0;
  localparam logic [SEL_W-1:0] STAT_RD    = 3'd1;
  localparam logic [SEL_W-1:0] STAT_OPEN  = 3'd2;
  localparam logic [SEL_W-1:0] STAT_RDBLK = 3'd3;
  localparam logic [SEL_W-1:0] STAT_WRBLK = 3'd4;

  typedef struct packed {
    op_t               op;
    logic              nonblock;
    logic [DATA_W-1:0] wdata;
    logic              last;
    logic [LEN_W-1:0]  len;
    logic [SEL_W-1:0]  sel;
    logic              needs_out;
  } cmd_t;
endpackage
`default_nettype wire

// ===== rtl/core/brfs_front.sv =====
// Front end: accepts input words, decodes and queues commands.
`default_nettype none
module brfs_front import brfs_pkg::*; #(
  parameter int MAX_READ = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic                  in_tlast,
  input  wire logic [2:0]            in_tuser,
  output logic                       q_valid,
  output cmd_t                       q_cmd,
  input  wire logic                  q_pop
);
  cmd_t       q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       dec;
  logic       keep;
  logic       push;

  always_comb begin
    dec.op        = op_t'(in_tuser);
    dec.nonblock  = in_tdata[0];
    dec.wdata     = in_tdata[8:1];
    dec.last      = in_tlast;
    dec.len       = in_tdata[15:9];
    dec.sel       = in_tdata[18:16];
    if (in_tdata[15:9] > LEN_W'(MAX_READ)) begin
      dec.len = LEN_W'(MAX_READ);
    end
    dec.needs_out = !(dec.op == OP_WRITE && !in_tlast);
    case (op_t'(in_tuser))
      OP_WRITE, OP_READ, OP_OPEN, OP_QUERY, OP_CLEAR: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready && keep;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_cmd     = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/brfs_back.sv =====
// Back end: ring storage, burst tracking, statistics and result register.
`default_nettype none
`include "byte_ring_fifo_with_stats_defines.svh"
module brfs_back import brfs_pkg::*; #(
  parameter int DEPTH      = 1024,
  parameter int STAT_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [SIZE_W-1:0]      cfg_data,
  input  wire logic                   q_valid,
  input  wire cmd_t                   q_cmd,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tlast,
  output logic [1:0]                  out_tuser
);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = $clog2(DEPTH);
  localparam int EW = (CW > SIZE_W) ? CW : SIZE_W;

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_READ = 2'b10
  } bk_state_t;

  typedef enum logic [3:0] {
    BS_IDLE      = 4'b0001,
    BS_ACCEPT    = 4'b0010,
    BS_REJ_BLOCK = 4'b0100,
    BS_REJ_AGAIN = 4'b1000
  } burst_t;

  logic [DATA_W-1:0]     mem [DEPTH];
  logic [DATA_W-1:0]     mem_q_r;
  logic                  mem_we, mem_re;

  logic [SIZE_W-1:0]     size_r, size_nxt;
  logic [PW-1:0]         wptr_r, wptr_nxt;
  logic [PW-1:0]         rptr_r, rptr_nxt;
  logic [CW-1:0]         fill_r, fill_nxt;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  burst_t                burst_r, burst_nxt;
  bk_state_t             st_r, st_nxt;
  logic [LEN_W-1:0]      rem_r, rem_nxt;
  logic [LEN_W-1:0]      nread_r, nread_nxt;
  logic [STAT_WIDTH-1:0] cnt_r [NUM_STATS];
  logic [NUM_STATS-1:0]  inc_en;
  logic [STAT_WIDTH-1:0] inc_amt [NUM_STATS];
  logic                  clr;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_byte_r;
  logic                  out_last_r;
  logic [1:0]            out_status_r;
  logic [MOVED_W-1:0]    out_moved_r;
  logic [LEVEL_W-1:0]    out_level_r;
  logic [SV_W-1:0]       out_sv_r;

  logic                  out_load, ld_byte, ld_last;
  logic [1:0]            ld_status;
  logic [MOVED_W-1:0]    ld_moved;
  logic [SV_W-1:0]       ld_sv;
  logic                  out_free;

  logic [EW-1:0]         size_ext, eff, fill_ext, wptr_inc, rptr_inc;
  logic [PW-1:0]         wptr_adv, rptr_adv;
  logic [31:0]           fill32, lvl32;
  logic [63:0]           sv64;
  logic [LEN_W-1:0]      n;
  burst_t                bs;
  logic [ACC_W-1:0]      acc;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    size_ext = EW'(size_r);
    if (size_r == '0) begin
      eff = EW'(1);
    end else if (size_ext > EW'(DEPTH)) begin
      eff = EW'(DEPTH);
    end else begin
      eff = size_ext;
    end
    fill_ext = EW'(fill_r);
    wptr_inc = EW'(wptr_r) + EW'(1);
    rptr_inc = EW'(rptr_r) + EW'(1);
    wptr_adv = (wptr_inc >= eff) ? '0 : wptr_inc[PW-1:0];
    rptr_adv = (rptr_inc >= eff) ? '0 : rptr_inc[PW-1:0];
    fill32   = 32'(fill_r);
    sv64     = (q_cmd.sel < SEL_W'(NUM_STATS)) ? 64'(cnt_r[q_cmd.sel]) : 64'd0;
  end

  always_comb begin
    size_nxt      = cfg_valid ? cfg_data : size_r;
    wptr_nxt      = wptr_r;
    rptr_nxt      = rptr_r;
    fill_nxt      = fill_r;
    acc_nxt       = acc_r;
    burst_nxt     = burst_r;
    st_nxt        = st_r;
    rem_nxt       = rem_r;
    nread_nxt     = nread_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    inc_en        = '0;
    clr           = 1'b0;
    out_load      = 1'b0;
    ld_byte       = 1'b0;
    ld_last       = 1'b1;
    ld_status     = ST_OK;
    ld_moved      = '0;
    ld_sv         = '0;
    bs            = burst_r;
    acc           = acc_r;
    n             = (EW'(q_cmd.len) < fill_ext) ? q_cmd.len : fill32[LEN_W-1:0];
    out_valid_nxt = (out_valid_r && out_tready) ? 1'b0 : out_valid_r;
    case (st_r)
      BK_IDLE: begin
        if (q_valid && (out_free || !q_cmd.needs_out)) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            OP_WRITE: begin
              if (burst_r == BS_IDLE) begin
                acc = '0;
                if (fill_ext >= eff) begin
                  if (q_cmd.nonblock) begin
                    bs = BS_REJ_AGAIN;
                  end else begin
                    bs = BS_REJ_BLOCK;
                    inc_en[STAT_WRBLK] = 1'b1;
                  end
                end else begin
                  bs = BS_ACCEPT;
                end
              end
              if (bs == BS_ACCEPT && fill_ext < eff) begin
                mem_we   = 1'b1;
                wptr_nxt = wptr_adv;
                fill_nxt = fill_r + CW'(1);
                if (acc != '1) begin
                  acc = acc + ACC_W'(1);
                end
                inc_en[STAT_WR] = 1'b1;
              end
              if (q_cmd.last) begin
                out_load  = 1'b1;
                ld_status = (bs == BS_REJ_BLOCK) ? ST_BLOCK :
                            (bs == BS_REJ_AGAIN) ? ST_AGAIN : ST_OK;
                ld_moved  = (ld_status == ST_OK) ? MOVED_W'(acc) : '0;
                burst_nxt = BS_IDLE;
                acc_nxt   = '0;
              end else begin
                burst_nxt = bs;
                acc_nxt   = acc;
              end
            end
            OP_READ: begin
              if (q_cmd.len == '0) begin
                out_load = 1'b1;
              end else if (fill_r == '0) begin
                out_load  = 1'b1;
                ld_status = q_cmd.nonblock ? ST_AGAIN : ST_BLOCK;
                inc_en[STAT_RDBLK] = !q_cmd.nonblock;
              end else begin
                fill_nxt = fill_r - CW'(n);
                inc_en[STAT_RD] = 1'b1;
                rem_nxt   = n;
                nread_nxt = n;
                st_nxt    = BK_READ;
              end
            end
            OP_OPEN: begin
              out_load = 1'b1;
              inc_en[STAT_OPEN] = 1'b1;
            end
            OP_QUERY: begin
              out_load = 1'b1;
              ld_sv    = sv64[SV_W-1:0];
            end
            OP_CLEAR: begin
              out_load = 1'b1;
              clr      = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      BK_READ: begin
        if (out_free) begin
          mem_re   = 1'b1;
          rptr_nxt = rptr_adv;
          rem_nxt  = rem_r - LEN_W'(1);
          out_load = 1'b1;
          ld_byte  = 1'b1;
          ld_last  = (rem_r == LEN_W'(1));
          ld_moved = ld_last ? MOVED_W'(nread_r) : '0;
          if (ld_last) begin
            st_nxt = BK_IDLE;
          end
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign lvl32 = 32'(fill_nxt);

  always_comb begin
    for (int i = 0; i < NUM_STATS; i++) begin
      inc_amt[i] = (SEL_W'(i) == STAT_RD) ? STAT_WIDTH'(n) : STAT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= SIZE_RESET;
      wptr_r      <= '0;
      rptr_r      <= '0;
      fill_r      <= '0;
      acc_r       <= '0;
      burst_r     <= BS_IDLE;
      st_r        <= BK_IDLE;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      size_r      <= size_nxt;
      wptr_r      <= wptr_nxt;
      rptr_r      <= rptr_nxt;
      fill_r      <= fill_nxt;
      acc_r       <= acc_nxt;
      burst_r     <= burst_nxt;
      st_r        <= st_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      for (int i = 0; i < NUM_STATS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_STATS; i++) begin
        if (inc_en[i]) begin
          cnt_r[i] <= cnt_r[i] + inc_amt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    nread_r <= nread_nxt;
    if (out_load) begin
      out_byte_r   <= ld_byte;
      out_last_r   <= ld_last;
      out_status_r <= ld_status;
      out_moved_r  <= ld_moved;
      out_level_r  <= lvl32[LEVEL_W-1:0];
      out_sv_r     <= ld_sv;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wptr_r] <= q_cmd.wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[rptr_r];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_sv_r, out_level_r, out_moved_r,
                       (out_byte_r ? mem_q_r : 8'd0)};

  `BRFS_ASSERT(a_fill_bound, fill_r <= CW'(DEPTH), "fill level above depth")
  `BRFS_NEVER(a_read_rem, st_r == BK_READ && rem_r == '0, "read state with no bytes left")
  `BRFS_ASSERT(a_read_end, st_r == BK_READ && out_free && rem_r == LEN_W'(1) |=> st_r == BK_IDLE, "read did not end after last byte")
  `BRFS_NEVER(a_rej_write, mem_we && (burst_r == BS_REJ_BLOCK || burst_r == BS_REJ_AGAIN), "byte stored in rejected burst")
endmodule
`default_nettype wire

// ===== rtl/core/byte_ring_fifo_with_stats.sv =====
// Top level of the byte ring FIFO with statistics counters.
// Write, open, query and clear words are taken one per cycle unless the engine
// stalls; a read of n bytes (n = min(len, fill)) sizes the transfer, then gives one
// byte per cycle from the ring memory's registered read port, and an empty or
// zero-length read gives one result word. A two-word command queue sits between
// the decoder and the engine. The engine stalls during a read, and for all but
// mid-burst writes while a result is not taken. No clearing pass runs after reset.
`default_nettype none
module byte_ring_fifo_with_stats import brfs_pkg::*; #(
  parameter int DEPTH      = 1024,
  parameter int MAX_READ   = 64,
  parameter int STAT_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [SIZE_W-1:0]      cfg_data,      // size_in_use
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // nonblock[0], write_data[8:1], read_len[15:9], stat_select[18:16]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   in_tlast,      // burst_last
  input  wire logic [2:0]             in_tuser,      // op
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // read_data[7:0], moved[18:8], level[29:19], stat_value[61:30]
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tlast,     // last
  output logic [1:0]                  out_tuser      // status
);
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  brfs_front #(
    .MAX_READ (MAX_READ)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  brfs_back #(
    .DEPTH      (DEPTH),
    .STAT_WIDTH (STAT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );
endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for byte_ring_fifo_with_stats: directed and random words, every reply checked.
module tb;
  import brfs_pkg::*;

  localparam int RING     = 1024;
  localparam int READ_MAX = 64;
  localparam int SETTLE   = 16;
  localparam int LIMIT    = 500000;

  typedef enum logic [1:0] {B_IDLE, B_ACCEPT, B_REJ_BLOCK, B_REJ_AGAIN} burst_e;

  typedef struct packed {
    logic [2:0]        op;
    logic              nonblock;
    logic [DATA_W-1:0] data;
    logic              last;
    logic [LEN_W-1:0]  len;
    logic [SEL_W-1:0]  sel;
  } word_t;

  typedef struct packed {
    logic [DATA_W-1:0]  data;
    logic               last;
    logic [1:0]         status;
    logic [MOVED_W-1:0] moved;
    logic [LEVEL_W-1:0] level;
    logic [SV_W-1:0]    stat;
  } reply_t;

  class ring_fifo_mirror;
    logic [DATA_W-1:0] ring [RING];
    int unsigned       wr_ptr, rd_ptr, fill, taken;
    burst_e            burst;
    logic [SV_W-1:0]   counts [NUM_STATS];
    logic [SIZE_W-1:0] size_reg;
    reply_t            replies_due [$];
    int                errors;

    function new();
      wr_ptr = 0;
      rd_ptr = 0;
      fill = 0;
      taken = 0;
      burst = B_IDLE;
      foreach (counts[i]) counts[i] = '0;
      foreach (ring[i]) ring[i] = '0;
      size_reg = SIZE_RESET;
      errors = 0;
    endfunction

    function int unsigned span();
      if (size_reg == 0) return 1;
      if (size_reg > RING) return RING;
      return size_reg;
    endfunction

    function int unsigned next_slot(int unsigned p);
      return (p + 1 >= span()) ? 0 : p + 1;
    endfunction

    function void queue_reply(logic [DATA_W-1:0] d, logic fin, logic [1:0] st,
                              int unsigned mv, logic [SV_W-1:0] sv);
      reply_t r;
      r.data = d;
      r.last = fin;
      r.status = st;
      r.moved = mv[MOVED_W-1:0];
      r.level = fill[LEVEL_W-1:0];
      r.stat = sv;
      replies_due.push_back(r);
    endfunction

    function void take_word(word_t w);
      int unsigned n, len, k;
      logic [1:0] st;
      logic [DATA_W-1:0] d;
      case (w.op)
        OP_WRITE: begin
          if (burst == B_IDLE) begin
            taken = 0;
            if (fill >= span()) burst = w.nonblock ? B_REJ_AGAIN : B_REJ_BLOCK;
            else burst = B_ACCEPT;
            if (burst == B_REJ_BLOCK) counts[STAT_WRBLK] += 1;
          end
          if (burst == B_ACCEPT && fill < span()) begin
            ring[wr_ptr] = w.data;
            wr_ptr = next_slot(wr_ptr);
            fill++;
            if (taken < 2047) taken++;
            counts[STAT_WR] += 1;
          end
          if (w.last) begin
            st = (burst == B_REJ_BLOCK) ? ST_BLOCK : (burst == B_REJ_AGAIN) ? ST_AGAIN : ST_OK;
            queue_reply('0, 1'b1, st, (st == ST_OK) ? taken : 0, '0);
            burst = B_IDLE;
            taken = 0;
          end
        end
        OP_READ: begin
          len = (w.len > READ_MAX) ? READ_MAX : w.len;
          if (len == 0) begin
            queue_reply('0, 1'b1, ST_OK, 0, '0);
          end else if (fill == 0) begin
            if (!w.nonblock) counts[STAT_RDBLK] += 1;
            queue_reply('0, 1'b1, w.nonblock ? ST_AGAIN : ST_BLOCK, 0, '0);
          end else begin
            n = (len < fill) ? len : fill;
            fill -= n;
            counts[STAT_RD] += n;
            for (k = 0; k < n; k++) begin
              d = ring[rd_ptr];
              rd_ptr = next_slot(rd_ptr);
              queue_reply(d, k + 1 == n, ST_OK, (k + 1 == n) ? n : 0, '0);
            end
          end
        end
        OP_OPEN: begin
          counts[STAT_OPEN] += 1;
          queue_reply('0, 1'b1, ST_OK, 0, '0);
        end
        OP_QUERY: begin
          queue_reply('0, 1'b1, ST_OK, 0, (w.sel < NUM_STATS) ? counts[w.sel] : '0);
        end
        OP_CLEAR: begin
          foreach (counts[i]) counts[i] = '0;
          queue_reply('0, 1'b1, ST_OK, 0, '0);
        end
        default: ;
      endcase
    endfunction

    function string show(reply_t r);
      return $sformatf("data=%h last=%b status=%0d moved=%0d level=%0d stat=%0d",
                       r.data, r.last, r.status, r.moved, r.level, r.stat);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: mismatch: expected no word, got %s", $time, show(got));
        return;
      end
      want = replies_due.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: mismatch: expected %s, got %s", $time, show(want), show(got));
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [SIZE_W-1:0]      cfg_data   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic [2:0]             in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic [1:0]             out_tuser;

  bit              steady = 1'b0;
  int unsigned     cycles = 0;
  ring_fifo_mirror sb = new();

  byte_ring_fifo_with_stats u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 20);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end else if (rst_n && out_tvalid && out_tready) begin
      sb.check_reply({out_tdata[7:0], out_tlast, out_tuser, out_tdata[18:8],
                      out_tdata[29:19], out_tdata[61:30]});
    end
  end

  function automatic word_t any_word(logic [2:0] op);
    word_t w;
    w.op = op;
    w.nonblock = 1'($urandom_range(1));
    w.data = 8'($urandom);
    w.last = 1'($urandom_range(1));
    w.len = ($urandom_range(9) == 0) ? 7'($urandom_range(65, 127)) : 7'($urandom_range(0, 64));
    w.sel = 3'($urandom_range(7));
    return w;
  endfunction

  task automatic send(word_t w);
    if (!steady && $urandom_range(99) < 20) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= w.op;
    in_tlast  <= w.last;
    in_tdata  <= {5'b0, w.sel, w.len, w.data, w.nonblock};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_word(w);
  endtask

  // burst of n bytes; other ops slip in before each byte at mix_pct percent
  task automatic burst(int unsigned n, logic nb, int unsigned mix_pct);
    int unsigned i;
    word_t w;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(99) < mix_pct) send(any_word(3'($urandom_range(1, 7))));
      w = any_word(OP_WRITE);
      if (i == 0) w.nonblock = nb;
      w.last = (i == n - 1);
      send(w);
    end
  endtask

  task automatic drain_replies();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain_replies();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_size(logic [SIZE_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.size_reg = v;
  endtask

  task automatic empty_ring();
    word_t w;
    while (sb.fill != 0) begin
      w = any_word(OP_READ);
      w.len = 7'($urandom_range(64, 127));
      send(w);
    end
  endtask

  task automatic wander(int unsigned count);
    int unsigned done, pick, n;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        n = ($urandom_range(7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
        burst(n, 1'($urandom_range(1)), 15);
        done += n;
      end else if (pick < 70) begin
        send(any_word(OP_READ));
        done++;
      end else if (pick < 80) begin
        send(any_word(OP_OPEN));
        done++;
      end else if (pick < 90) begin
        send(any_word(OP_QUERY));
        done++;
      end else if (pick < 93) begin
        send(any_word(OP_CLEAR));
        done++;
      end else if (pick < 97) begin
        send(any_word(3'($urandom_range(5, 7))));
      end else begin
        drain_replies();
      end
    end
  endtask

  initial begin
    int unsigned i;
    word_t w;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty ring
    w = any_word(OP_QUERY);
    w.sel = STAT_WR;
    send(w);
    send(any_word(OP_OPEN));
    w = any_word(OP_READ);
    w.len = 7'd5;
    w.nonblock = 1'b0;
    send(w);
    w.nonblock = 1'b1;
    send(w);
    w.len = '0;
    send(w);

    // large ring never wraps here, so the low slots all get written
    steady = 1'b1;
    burst(20, 1'b0, 0);
    wander(10);
    steady = 1'b0;
    set_size(11'd2047);
    wander(10);

    // full ring: first byte of a burst decides blocked vs try-again
    set_size(11'd8);
    burst(10, 1'b0, 0);
    w = any_word(OP_WRITE);
    w.nonblock = 1'b0;
    w.last = 1'b0;
    send(w);
    w.nonblock = 1'b1;
    w.last = 1'b1;
    send(w);
    send(w);
    for (i = 0; i < 8; i++) begin
      w = any_word(OP_QUERY);
      w.sel = 3'(i);
      send(w);
    end

    empty_ring();
    w = any_word(OP_READ);
    w.len = 7'd127;
    w.nonblock = 1'b0;
    send(w);
    send(any_word(OP_CLEAR));
    w = any_word(OP_QUERY);
    w.sel = STAT_RDBLK;
    send(w);
    for (i = 5; i < 8; i++) send(any_word(3'(i)));

    // sizes stay within the slots written above
    set_size(11'd1);
    wander(8);
    set_size(11'd7);
    wander(8);
    steady = 1'b1;
    set_size(11'd16);
    wander(10);
    steady = 1'b0;
    set_size(11'd0);
    wander(8);
    set_size(11'($urandom_range(2, 15)));
    wander(8);
    set_size(11'd3);
    wander(8);

    settle();
    if (sb.errors == 0 && sb.replies_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/brfs_pkg.sv
rtl/core/brfs_front.sv
rtl/core/brfs_back.sv
rtl/core/byte_ring_fifo_with_stats.sv
bench/tb.sv
